// ----- rtl/core/tdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_pkg: shared types and constants of the tile deduplication dictionary
// Sizes of the tile store, field widths and the controller state encoding.
// ----------------------------------------------------------------------------
package tdd_pkg;

	// Storage size and the part of it that the 8-bit index can reach
	localparam int DICT_DEPTH = 256;
	localparam int CAPACITY   = (DICT_DEPTH < 256) ? DICT_DEPTH : 256;
	localparam int ADDR_W     = $clog2(CAPACITY);

	// Field widths
	localparam int TILE_W  = 64;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;

	// Preloaded entries
	localparam logic [TILE_W-1:0]  TILE_ZEROS = '0;
	localparam logic [TILE_W-1:0]  TILE_ONES  = '1;
	localparam logic [INDEX_W-1:0] IDX_ZEROS  = 8'h00;
	localparam logic [INDEX_W-1:0] IDX_ONES   = 8'h01;
	localparam logic [COUNT_W-1:0] FILL_RESET = 9'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} tdd_state_t;

endpackage

// ----- rtl/core/tile_dedup_dictionary.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_dedup_dictionary: 8-byte tile dictionary with sequential search
// Looks each tile up in a dictionary memory, appends unseen tiles and
// returns the entry index, new/overflow flags and the fill level.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | tile_bits
//  out     | out_valid / out_ready| tile_index, is_new, overflow, entries_used
//
//  An all-zero or all-ones tile skips the scan and goes from accept through
//  the hold state to the output register. Any other tile is compared against
//  stored entries 2..n-1, one memory read per cycle (n = entries in use, at
//  most 256), and the scan stops early on a match; while only the two
//  preloaded entries are in use, the tile is appended without a memory read.
//  The single read port of the tile memory sets the pace of the scan.
//  Reset loads the fill level with 2; entries 0 and 1 are fixed constants and
//  need no memory initialization, so the block is ready right after reset.
//  A stalled output holds the next result in the controller and blocks input.
// ----------------------------------------------------------------------------
module tile_dedup_dictionary
	import tdd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TILE_W-1:0]   tile_bits,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [INDEX_W-1:0]  tile_index,
	output logic                is_new,
	output logic                overflow,
	output logic [COUNT_W-1:0]  entries_used
);

	// Tile memory (entries 0 and 1 are never stored here)
	logic [TILE_W-1:0] mem [CAPACITY];

	tdd_state_t state_q, state_d;

	logic [TILE_W-1:0]  tile_q;
	logic [COUNT_W-1:0] fill_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  rd_addr_s1;
	logic [TILE_W-1:0]  rd_data_s1;

	logic [INDEX_W-1:0] res_index_q;
	logic               res_new_q;
	logic               res_ovf_q;

	logic               out_valid_q;
	logic [INDEX_W-1:0] out_index_q;
	logic               out_new_q;
	logic               out_ovf_q;
	logic [COUNT_W-1:0] out_used_q;

	logic in_fire;
	logic preload_hit;
	logic hit;
	logic issue;
	logic drained;
	logic room;
	logic out_free;
	logic load_out;

	// Handshake and scan control
	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign preload_hit = (tile_bits == TILE_ZEROS) || (tile_bits == TILE_ONES);
	assign hit         = (state_q == S_SCAN) && rd_vld_s1 && (rd_data_s1 == tile_q);
	assign issue       = (state_q == S_SCAN) && !hit && (rd_idx_q < fill_q);
	assign drained     = (state_q == S_SCAN) && !hit && !rd_vld_s1 && (rd_idx_q == fill_q);
	assign room        = (fill_q < COUNT_W'(CAPACITY));
	assign out_free    = !out_valid_q || out_ready;
	assign load_out    = (state_q == S_HOLD) && out_free;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = preload_hit ? S_HOLD : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || drained) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers: read pipeline valid, fill level, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			fill_q      <= FILL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (drained && room) begin
				fill_q <= fill_q + COUNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Memory: read one entry per scan cycle, append on a miss with room
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
		end
		if (drained && room) begin
			mem[fill_q[ADDR_W-1:0]] <= tile_q;
		end
	end

	// Datapath: capture tile, advance read address, settle result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tile_q      <= tile_bits;
			rd_idx_q    <= FILL_RESET;
			res_index_q <= (tile_bits == TILE_ONES) ? IDX_ONES : IDX_ZEROS;
			res_new_q   <= 1'b0;
			res_ovf_q   <= 1'b0;
		end
		if (issue) begin
			rd_idx_q   <= rd_idx_q + COUNT_W'(1);
			rd_addr_s1 <= rd_idx_q[ADDR_W-1:0];
		end
		if (hit) begin
			res_index_q <= INDEX_W'(rd_addr_s1);
		end else if (drained) begin
			if (room) begin
				res_index_q <= INDEX_W'(fill_q[ADDR_W-1:0]);
				res_new_q   <= 1'b1;
			end else begin
				res_index_q <= IDX_ZEROS;
				res_ovf_q   <= 1'b1;
			end
		end
		if (load_out) begin
			out_index_q <= res_index_q;
			out_new_q   <= res_new_q;
			out_ovf_q   <= res_ovf_q;
			out_used_q  <= fill_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign tile_index   = out_index_q;
	assign is_new       = out_new_q;
	assign overflow     = out_ovf_q;
	assign entries_used = out_used_q;

endmodule

// ----- rtl/core/tdd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_checker: port-level checks for the tile deduplication dictionary
// Watches the result word for consistent flags, index and fill level.
// ----------------------------------------------------------------------------
module tdd_checker
	import tdd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [INDEX_W-1:0] tile_index,
	input logic               is_new,
	input logic               overflow,
	input logic [COUNT_W-1:0] entries_used
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tile_index) && $stable(entries_used))
		else $error("stalled result word changed");

	// Never flag a word as both new and overflow
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && overflow))
		else $error("new and overflow both set");

	// Overflow only when full, with index zero
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> tile_index == IDX_ZEROS
			&& entries_used == COUNT_W'(CAPACITY))
		else $error("overflow word inconsistent");

	// A new entry is the last one in use
	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_new |-> entries_used == ({1'b0, tile_index} + COUNT_W'(1)))
		else $error("new entry index does not match fill level");

endmodule

bind tile_dedup_dictionary tdd_checker u_tdd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.tile_index   (tile_index),
	.is_new       (is_new),
	.overflow     (overflow),
	.entries_used (entries_used)
);
